// ----- design/depth_pixel_backprojection_defines.svh -----
// assertion macros for the depth pixel back-projection block
// used by the top level; no other dependencies
`ifndef DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH
`define DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH
`ifndef SYNTHESIS
`define DPB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define DPB_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define DPB_ASSERT(lbl, prop, msg)
`define DPB_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ----- design/dpb_pkg.sv -----
// types, register indexes and reset values for depth pixel back-projection
// no dependencies
`default_nettype none
package dpb_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int CENTER_FRAC    = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_SCALE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_X     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y     = 3'd4;

    localparam logic [15:0] RST_DEPTH_SCALE = 16'd1000;
    localparam logic [15:0] RST_CENTER_X    = 16'd5208;
    localparam logic [15:0] RST_CENTER_Y    = 16'd4056;
    localparam logic [15:0] RST_FOCAL_X     = 16'd8288;
    localparam logic [15:0] RST_FOCAL_Y     = 16'd8288;

    typedef struct packed {
        logic [11:0] column;
        logic [11:0] line;
        logic [15:0] depth_raw;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } t_pix_in;

    typedef struct packed {
        logic signed [47:0] point_x;
        logic signed [47:0] point_y;
        logic [31:0]        point_z;
        logic [7:0]         out_blue;
        logic [7:0]         out_green;
        logic [7:0]         out_red;
    } t_point_out;

endpackage
`default_nettype wire

// ----- design/depth_pixel_backprojection.sv -----
// pinhole back-projection of one rgb-d pixel per transfer, fully pipelined
// divider width: NUM_W = max(COORD_BITS+4,16) + 16 + FRAC_BITS, 48 by default
// throughput: one pixel per cycle unless the output stalls; the bit-serial divider stages set the depth
// an output stall freezes the whole pipeline, nothing is dropped
// reset (synchronous, active low) clears valid bits and loads register defaults
`default_nettype none
`include "depth_pixel_backprojection_defines.svh"
module depth_pixel_backprojection
    import dpb_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire t_pix_in               i_pix,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output t_point_out                 o_point,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int MAG_W  = (COORD_BITS + CENTER_FRAC > 16) ? COORD_BITS + CENTER_FRAC : 16;
    localparam int PROD_W = MAG_W + 16;
    localparam int NUM_W  = PROD_W + FRAC_BITS;
    localparam int DEN_W  = 32;
    localparam int QE_W   = (NUM_W > 49) ? NUM_W : 49;
    localparam int META_W = 2 + 24;

    // configuration registers
    logic [15:0] r_depth_scale, r_center_x, r_center_y, r_focal_x, r_focal_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_scale <= RST_DEPTH_SCALE;
            r_center_x    <= RST_CENTER_X;
            r_center_y    <= RST_CENTER_Y;
            r_focal_x     <= RST_FOCAL_X;
            r_focal_y     <= RST_FOCAL_Y;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_DEPTH_SCALE: r_depth_scale <= i_cfg_data;
                CFG_CENTER_X:    r_center_x    <= i_cfg_data;
                CFG_CENTER_Y:    r_center_y    <= i_cfg_data;
                CFG_FOCAL_X:     r_focal_x     <= i_cfg_data;
                CFG_FOCAL_Y:     r_focal_y     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // divisors follow the registers every cycle; zero is taken as one
    logic [15:0]      scale_eff, fx_eff, fy_eff;
    logic [DEN_W-1:0] r_den_x, r_den_y, r_den_z;

    assign scale_eff = (r_depth_scale == '0) ? 16'd1 : r_depth_scale;
    assign fx_eff    = (r_focal_x == '0) ? 16'd1 : r_focal_x;
    assign fy_eff    = (r_focal_y == '0) ? 16'd1 : r_focal_y;

    always_ff @(posedge i_clk) begin
        r_den_x <= fx_eff * scale_eff;
        r_den_y <= fy_eff * scale_eff;
        r_den_z <= DEN_W'(scale_eff);
    end

    logic adv;
    logic r_out_vld;
    assign adv     = !(r_out_vld && i_stall);
    assign o_stall = !adv;

    // stage 1: offsets from the principal point
    logic [15:0]      col_w, row_w;
    logic [MAG_W-1:0] c16_x, c16_y, cen_x, cen_y, mag_x, mag_y;
    logic             neg_x, neg_y;

    assign col_w = 16'(i_pix.column);
    assign row_w = 16'(i_pix.line);
    assign c16_x = MAG_W'({col_w[COORD_BITS-1:0], {CENTER_FRAC{1'b0}}});
    assign c16_y = MAG_W'({row_w[COORD_BITS-1:0], {CENTER_FRAC{1'b0}}});
    assign cen_x = MAG_W'(r_center_x);
    assign cen_y = MAG_W'(r_center_y);
    assign neg_x = c16_x < cen_x;
    assign neg_y = c16_y < cen_y;
    assign mag_x = neg_x ? cen_x - c16_x : c16_x - cen_x;
    assign mag_y = neg_y ? cen_y - c16_y : c16_y - cen_y;

    logic             r_s1_vld;
    logic [MAG_W-1:0] r_s1_mag_x, r_s1_mag_y;
    logic [15:0]      r_s1_depth;
    logic [META_W-1:0] r_s1_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (adv) begin
            // zero depth is no measurement: the pixel is dropped here
            r_s1_vld <= i_valid && (i_pix.depth_raw != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_mag_x <= mag_x;
            r_s1_mag_y <= mag_y;
            r_s1_depth <= i_pix.depth_raw;
            r_s1_meta  <= {neg_x, neg_y, i_pix.blue, i_pix.green, i_pix.red};
        end
    end

    // stage 2: numerator products
    logic              r_s2_vld;
    logic [PROD_W-1:0] r_prod_x, r_prod_y;
    logic [15:0]       r_s2_depth;
    logic [META_W-1:0] r_s2_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (adv) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_prod_x   <= r_s1_mag_x * r_s1_depth;
            r_prod_y   <= r_s1_mag_y * r_s1_depth;
            r_s2_depth <= r_s1_depth;
            r_s2_meta  <= r_s1_meta;
        end
    end

    // divider stages, valid and side data travel alongside
    logic [NUM_W-1:0] num_x, num_y, num_z, quo_x, quo_y, quo_z;

    assign num_x = {r_prod_x, {FRAC_BITS{1'b0}}};
    assign num_y = {r_prod_y, {FRAC_BITS{1'b0}}};
    assign num_z = NUM_W'({r_s2_depth, {FRAC_BITS{1'b0}}});

    dpb_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_x (
        .i_clk(i_clk), .i_en(adv), .i_num(num_x), .i_den(r_den_x), .o_quo(quo_x)
    );
    dpb_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_y (
        .i_clk(i_clk), .i_en(adv), .i_num(num_y), .i_den(r_den_y), .o_quo(quo_y)
    );
    dpb_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_z (
        .i_clk(i_clk), .i_en(adv), .i_num(num_z), .i_den(r_den_z), .o_quo(quo_z)
    );

    logic [NUM_W-1:0]  r_dvld;
    logic [META_W-1:0] r_dmeta [NUM_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvld <= '0;
        end else if (adv) begin
            r_dvld <= {r_dvld[NUM_W-2:0], r_s2_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dmeta[0] <= r_s2_meta;
            for (int i = 1; i < NUM_W; i++) begin
                r_dmeta[i] <= r_dmeta[i-1];
            end
        end
    end

    // output stage: sign and saturation
    function automatic logic [47:0] sat_xy(input logic neg, input logic [QE_W-1:0] q);
        logic [QE_W-1:0] nq;
        logic [47:0]     res;
        nq = -q;
        if (neg) begin
            res = (q > QE_W'(48'h8000_0000_0000)) ? 48'h8000_0000_0000 : nq[47:0];
        end else begin
            res = (q > QE_W'(48'h7FFF_FFFF_FFFF)) ? 48'h7FFF_FFFF_FFFF : q[47:0];
        end
        return res;
    endfunction

    logic [QE_W-1:0]   qz;
    logic [META_W-1:0] meta_last;
    t_point_out        n_point;
    t_point_out        r_point;

    assign qz        = QE_W'(quo_z);
    assign meta_last = r_dmeta[NUM_W-1];

    always_comb begin
        n_point.point_x   = sat_xy(meta_last[25], QE_W'(quo_x));
        n_point.point_y   = sat_xy(meta_last[24], QE_W'(quo_y));
        n_point.point_z   = (qz > QE_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : qz[31:0];
        n_point.out_blue  = meta_last[23:16];
        n_point.out_green = meta_last[15:8];
        n_point.out_red   = meta_last[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_dvld[NUM_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_point <= n_point;
        end
    end

    assign o_valid = r_out_vld;
    assign o_point = r_point;

    `DPB_ASSERT(a_zero_depth_dropped, i_valid && !o_stall && (i_pix.depth_raw == '0) |=> !r_s1_vld, "zero depth entered the pipeline")
    `DPB_ASSERT(a_stall_freezes, o_valid && i_stall |-> o_stall, "pipeline moved under output stall")
    `DPB_ASSERT(a_s2_follows_s1, adv |=> (r_s2_vld == $past(r_s1_vld)), "stage 2 valid lost")
    `DPB_ASSERT_RST(a_reset_clears, !i_rst_n |=> !o_valid && !r_s1_vld, "valid set after reset")
endmodule
`default_nettype wire

// ----- design/dpb_div.sv -----
// pipelined restoring divider, one quotient bit per register stage
// no dependencies; the divisor must stay constant while items are in flight
`default_nettype none
module dpb_div #(
    parameter int NUM_W = 52,
    parameter int DEN_W = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic      [NUM_W-1:0] o_quo
);
    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [NUM_W-1:0] r_num [NUM_W];
    logic [NUM_W-1:0] r_quo [NUM_W];

    genvar k;
    for (k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [NUM_W-1:0] num_in;
        logic [NUM_W-1:0] quo_in;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign num_in = i_num;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign num_in = r_num[k-1];
            assign quo_in = r_quo[k-1];
        end

        // shift in the next numerator bit and try to subtract
        assign trial = {rem_in, num_in[NUM_W-1]};
        assign ge    = trial >= {1'b0, i_den};
        assign diff  = trial - {1'b0, i_den};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                r_num[k] <= num_in << 1;
                r_quo[k] <= {quo_in[NUM_W-2:0], ge};
            end
        end
    end

    assign o_quo = r_quo[NUM_W-1];
endmodule
`default_nettype wire
